### sv/speq_pkg.sv
package speq_pkg;

	// Default store depth; the top level takes it as a parameter.
	localparam int QUEUE_DEPTH_DEF = 32;

	// Stream payload widths in bits.
	localparam int ENTRY_W  = 74;
	localparam int TDATA_W  = 80;
	localparam int OCC_W    = 6;

	// Request kinds carried on s_tuser.
	localparam logic REQ_INSERT  = 1'b0;
	localparam logic REQ_DEQUEUE = 1'b1;

	// Result codes carried on m_tuser.
	typedef enum logic [1:0] {
		STS_INSERTED = 2'd0,
		STS_DROPPED  = 2'd1,
		STS_DEQUEUED = 2'd2,
		STS_EMPTY    = 2'd3
	} status_t;

	// One stored event; the packing matches the low bits of s_tdata.
	typedef struct packed {
		logic [31:0] time_ms;
		logic [31:0] reading;
		logic [1:0]  pri;
		logic [7:0]  sid;
	} entry_t;

endpackage

### sv/sorted_event_priority_queue.sv
// Sorted priority queue of sensor events, highest priority first, first in
// first out among equal priorities.
// Requests enter on the s_ group: s_tuser selects insert or dequeue, s_tdata
// carries the event. Each request yields exactly one result on the m_ group:
// m_tuser holds the status code, m_tdata the dequeued event (zero otherwise)
// and the occupancy after the request.
// Events live in a single-port-write, registered-read memory that is kept
// sorted. One shared read/compare/write step moves one entry per cycle:
// an insert walks from the tail toward the head, moving each lower-priority
// entry down by one, then drops the new event into the gap; a dequeue reads
// the head and moves every remaining entry up by one.
// A dropped insert or an empty dequeue skips the memory walk and goes straight
// to ST_DONE. s_tready rises again with m_tvalid, so a new request is not
// taken until the last one has finished.
// The result sits in an output register; a new request may be taken while it
// waits, but the next result holds until m_tready drains the register.
// Reset empties the queue (count to zero); memory contents need no clearing.
module sorted_event_priority_queue #(
	parameter int QUEUE_DEPTH = speq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// src_id[7:0], priority_req[9:8], reading_bits[41:10],
	// timestamp[73:42], zero pad[79:74]
	input  logic [speq_pkg::TDATA_W-1:0]  s_tdata,
	// req_type[0]
	input  logic [0:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// out_src_id[7:0], out_priority[9:8], out_reading_bits[41:10],
	// out_timestamp[73:42], occupancy[79:74]
	output logic [speq_pkg::TDATA_W-1:0]  m_tdata,
	// status[1:0]
	output logic [1:0]                    m_tuser
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [4:0] {
		ST_IDLE      = 5'b00001,
		ST_INS       = 5'b00010,
		ST_DEQ_HEAD  = 5'b00100,
		ST_DEQ_SHIFT = 5'b01000,
		ST_DONE      = 5'b10000
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         pos_q;
	speq_pkg::entry_t      new_q;
	speq_pkg::entry_t      res_q;
	speq_pkg::status_t     res_status_q;
	logic                  m_tvalid_q;
	logic [speq_pkg::TDATA_W-1:0] m_tdata_q;
	logic [1:0]            m_tuser_q;

	logic                  accept;
	logic                  full;
	logic                  shift_go;
	logic                  more_deq;
	logic                  out_free;
	logic [CW+speq_pkg::OCC_W-1:0] occ_ext;

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	speq_pkg::entry_t      mem_wdata;
	logic [AW-1:0]         mem_raddr;
	speq_pkg::entry_t      mem_rdata;

	speq_mem #(
		.DEPTH(QUEUE_DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CW'(QUEUE_DEPTH));
	// Move the entry above the gap down while it ranks strictly lower.
	assign shift_go = (pos_q != '0) && (mem_rdata.pri < new_q.pri);
	// Continue the dequeue shift while the next address pos_q + 1 is below the count.
	assign more_deq = ((CW'(pos_q) + CW'(1)) < count_q);
	assign out_free = !m_tvalid_q || m_tready;
	assign occ_ext  = {{speq_pkg::OCC_W{1'b0}}, count_q};

	// Memory port control: one read and at most one write each cycle.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = new_q;
		mem_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tuser[0] == speq_pkg::REQ_INSERT) begin
					mem_raddr = AW'(count_q - CW'(1));
				end
			end
			ST_INS: begin
				mem_we = 1'b1;
				if (shift_go) begin
					mem_wdata = mem_rdata;
					mem_raddr = pos_q - AW'(2);
				end
			end
			ST_DEQ_HEAD: begin
				mem_raddr = AW'(1);
			end
			ST_DEQ_SHIFT: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q - AW'(1);
				mem_wdata = mem_rdata;
				mem_raddr = pos_q + AW'(1);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Sequencer and queue count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser[0] == speq_pkg::REQ_INSERT) begin
							state_q <= full ? ST_DONE : ST_INS;
						end else begin
							state_q <= (count_q == '0) ? ST_DONE : ST_DEQ_HEAD;
						end
					end
				end
				ST_INS: begin
					if (!shift_go) begin
						count_q <= count_q + CW'(1);
						state_q <= ST_DONE;
					end
				end
				ST_DEQ_HEAD: begin
					if (count_q > CW'(1)) begin
						state_q <= ST_DEQ_SHIFT;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= ST_DONE;
					end
				end
				ST_DEQ_SHIFT: begin
					if (!more_deq) begin
						count_q <= count_q - CW'(1);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers: gap position, pending event and result.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					new_q <= speq_pkg::entry_t'(s_tdata[speq_pkg::ENTRY_W-1:0]);
					res_q <= '0;
					pos_q <= AW'(count_q);
					if (s_tuser[0] == speq_pkg::REQ_INSERT) begin
						res_status_q <= full ? speq_pkg::STS_DROPPED
						                     : speq_pkg::STS_INSERTED;
					end else begin
						res_status_q <= (count_q == '0) ? speq_pkg::STS_EMPTY
						                                : speq_pkg::STS_DEQUEUED;
					end
				end
			end
			ST_INS: begin
				if (shift_go) begin
					pos_q <= pos_q - AW'(1);
				end
			end
			ST_DEQ_HEAD: begin
				res_q <= mem_rdata;
				pos_q <= AW'(1);
			end
			ST_DEQ_SHIFT: begin
				pos_q <= pos_q + AW'(1);
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	// Output register: load in ST_DONE once the previous result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {occ_ext[speq_pkg::OCC_W-1:0], res_q};
			m_tuser_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

### sv/speq_mem.sv
module speq_mem #(
	parameter int DEPTH = speq_pkg::QUEUE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  speq_pkg::entry_t    wdata,
	input  logic [AW-1:0]       raddr,
	output speq_pkg::entry_t    rdata
);

	speq_pkg::entry_t mem_q [DEPTH];
	speq_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
